@@ rtl/vva_pkg.sv @@
package vva_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NW        = 32 + FRAC_BITS;
  localparam int DW        = 33;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = NW;

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_SCALE  = 4'd2,
    CMD_DIV    = 4'd3,
    CMD_DOT    = 4'd4,
    CMD_CROSS  = 4'd5,
    CMD_LEN    = 4'd6,
    CMD_LENSQ  = 4'd7,
    CMD_NORM   = 4'd8,
    CMD_EQUAL  = 4'd9
  } cmd_e;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic [15:0] TOL_RESET = 16'd7;
  localparam logic [65:0] HALF = 66'd1 << (FRAC_BITS - 1);

  typedef struct packed {
    cmd_e             cmd;
    logic [2:0][31:0] amag;
    logic [2:0]       aneg;
    logic [31:0]      scmag;
    logic             scneg;
    logic             sczero;
    logic [2:0][31:0] r;
    logic [31:0]      so;
    logic             eq;
    logic             ovf;
    logic             dz;
  } item_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic [65:0] mag66(input logic [65:0] v);
    return v[65] ? (~v + 66'd1) : v;
  endfunction

  // {overflow, saturated value}
  function automatic logic [32:0] sat_sm(input logic neg, input logic [65:0] m);
    logic [32:0] res;
    if (neg) begin
      if (m > 66'h80000000) res = {1'b1, 32'h80000000};
      else res = {1'b0, (~m[31:0]) + 32'd1};
    end else begin
      if (m > 66'h7fffffff) res = {1'b1, 32'h7fffffff};
      else res = {1'b0, m[31:0]};
    end
    return res;
  endfunction

  function automatic logic [32:0] rnd_sat(input logic [65:0] v);
    logic [65:0] m;
    m = (mag66(v) + HALF) >> FRAC_BITS;
    return sat_sm(v[65], m);
  endfunction

endpackage

@@ rtl/vec3_vector_alu_top.sv @@
// Three-component Q16.16 vector ALU. One command enters per cycle through the in_ stream and
// each result leaves in order on the out_ stream after passing through the pipeline (input
// stage, three multiply/sum stages, 33 square-root stages, 49 divider stages, output stage);
// the root takes 32 steps and the restoring divider 48. A stall on out_tready holds the whole
// pipeline. The user writes the tolerance register via cfg_ only while idle; not enforced.
module vec3_vector_alu_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [223:0] in_tdata,   // ax, ay, az, bx, by, bz, scalar_in
  input  logic [3:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // rx, ry, rz, scalar_out, equal_flag, zero fill
  output logic [1:0]   out_tuser,  // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  localparam int SQ = vva_pkg::SQ_STEPS;
  localparam int DV = vva_pkg::DIV_STEPS;
  localparam int NW = vva_pkg::NW;
  localparam int DW = vva_pkg::DW;

  logic adv;
  logic [15:0] tol_r;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= vva_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // stage A
  logic              a_v_r;
  vva_pkg::cmd_e     a_cmd_r;
  logic [2:0][31:0]  a_a_r, a_b_r;
  logic [31:0]       a_sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd_r <= vva_pkg::cmd_e'(in_tuser);
      for (int i = 0; i < 3; i++) begin
        a_a_r[i] <= in_tdata[32*i +: 32];
        a_b_r[i] <= in_tdata[96 + 32*i +: 32];
      end
      a_sc_r <= in_tdata[223:192];
    end
  end

  // operand select, add, sub, equal
  logic [5:0][31:0] b_opx_nxt, b_opy_nxt;
  logic [5:0]       b_oneg_nxt;
  vva_pkg::item_t   b_it_nxt;
  logic [2:0][31:0] a_bmag;
  logic [2:0]       a_bneg;
  logic [2:0][32:0] a_sum, a_dif;
  logic [2:0][32:0] a_sat;

  always_comb begin
    b_opx_nxt  = '0;
    b_opy_nxt  = '0;
    b_oneg_nxt = '0;
    b_it_nxt   = '0;
    b_it_nxt.cmd    = a_cmd_r;
    b_it_nxt.scmag  = vva_pkg::mag32(a_sc_r);
    b_it_nxt.scneg  = a_sc_r[31];
    b_it_nxt.sczero = (a_sc_r == 32'd0);
    for (int i = 0; i < 3; i++) begin
      b_it_nxt.amag[i] = vva_pkg::mag32(a_a_r[i]);
      b_it_nxt.aneg[i] = a_a_r[i][31];
      a_bmag[i] = vva_pkg::mag32(a_b_r[i]);
      a_bneg[i] = a_b_r[i][31];
      a_sum[i]  = {a_a_r[i][31], a_a_r[i]} + {a_b_r[i][31], a_b_r[i]};
      a_dif[i]  = {a_a_r[i][31], a_a_r[i]} - {a_b_r[i][31], a_b_r[i]};
      a_sat[i]  = '0;
    end
    unique case (a_cmd_r)
      vva_pkg::CMD_ADD, vva_pkg::CMD_SUB: begin
        for (int i = 0; i < 3; i++) begin
          if (a_cmd_r == vva_pkg::CMD_ADD) begin
            a_sat[i] = vva_pkg::sat_sm(a_sum[i][32], {33'd0, vva_pkg::mag33(a_sum[i])});
          end else begin
            a_sat[i] = vva_pkg::sat_sm(a_dif[i][32], {33'd0, vva_pkg::mag33(a_dif[i])});
          end
          b_it_nxt.r[i] = a_sat[i][31:0];
        end
        b_it_nxt.ovf = a_sat[0][32] | a_sat[1][32] | a_sat[2][32];
      end
      vva_pkg::CMD_EQUAL: begin
        b_it_nxt.eq = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (!(vva_pkg::mag33(a_dif[i]) < {17'd0, tol_r})) b_it_nxt.eq = 1'b0;
        end
      end
      vva_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          b_opx_nxt[2*i]  = b_it_nxt.amag[i];
          b_opy_nxt[2*i]  = b_it_nxt.scmag;
          b_oneg_nxt[2*i] = b_it_nxt.aneg[i] ^ a_sc_r[31];
        end
      end
      vva_pkg::CMD_DOT: begin
        for (int i = 0; i < 3; i++) begin
          b_opx_nxt[2*i]  = b_it_nxt.amag[i];
          b_opy_nxt[2*i]  = a_bmag[i];
          b_oneg_nxt[2*i] = b_it_nxt.aneg[i] ^ a_bneg[i];
        end
      end
      vva_pkg::CMD_LEN, vva_pkg::CMD_LENSQ, vva_pkg::CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          b_opx_nxt[2*i] = b_it_nxt.amag[i];
          b_opy_nxt[2*i] = b_it_nxt.amag[i];
        end
      end
      vva_pkg::CMD_CROSS: begin
        b_opx_nxt[0] = b_it_nxt.amag[1]; b_opy_nxt[0] = a_bmag[2];
        b_oneg_nxt[0] = b_it_nxt.aneg[1] ^ a_bneg[2];
        b_opx_nxt[1] = b_it_nxt.amag[2]; b_opy_nxt[1] = a_bmag[1];
        b_oneg_nxt[1] = ~(b_it_nxt.aneg[2] ^ a_bneg[1]);
        b_opx_nxt[2] = b_it_nxt.amag[2]; b_opy_nxt[2] = a_bmag[0];
        b_oneg_nxt[2] = b_it_nxt.aneg[2] ^ a_bneg[0];
        b_opx_nxt[3] = b_it_nxt.amag[0]; b_opy_nxt[3] = a_bmag[2];
        b_oneg_nxt[3] = ~(b_it_nxt.aneg[0] ^ a_bneg[2]);
        b_opx_nxt[4] = b_it_nxt.amag[0]; b_opy_nxt[4] = a_bmag[1];
        b_oneg_nxt[4] = b_it_nxt.aneg[0] ^ a_bneg[1];
        b_opx_nxt[5] = b_it_nxt.amag[1]; b_opy_nxt[5] = a_bmag[0];
        b_oneg_nxt[5] = ~(b_it_nxt.aneg[1] ^ a_bneg[0]);
      end
      default: begin
      end
    endcase
  end

  // stage B
  logic             b_v_r;
  logic [5:0][31:0] b_opx_r, b_opy_r;
  logic [5:0]       b_oneg_r;
  vva_pkg::item_t   b_it_r;

  // stage C
  logic             c_v_r;
  logic [5:0][63:0] c_prod_r;
  logic [5:0]       c_oneg_r;
  vva_pkg::item_t   c_it_r;

  // stage D
  logic             d_v_r;
  logic [2:0][65:0] d_pair_r;
  logic [65:0]      d_dsum_r;
  vva_pkg::item_t   d_it_r;
  logic [5:0][65:0] c_sp;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      c_sp[k] = c_oneg_r[k] ? (~{2'b00, c_prod_r[k]} + 66'd1) : {2'b00, c_prod_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_opx_r  <= b_opx_nxt;
      b_opy_r  <= b_opy_nxt;
      b_oneg_r <= b_oneg_nxt;
      b_it_r   <= b_it_nxt;
      for (int k = 0; k < 6; k++) c_prod_r[k] <= b_opx_r[k] * b_opy_r[k];
      c_oneg_r <= b_oneg_r;
      c_it_r   <= b_it_r;
      for (int k = 0; k < 3; k++) d_pair_r[k] <= c_sp[2*k] + c_sp[2*k+1];
      d_dsum_r <= c_sp[0] + c_sp[2] + c_sp[4];
      d_it_r   <= c_it_r;
    end
  end

  // rounding of products, root chain entry
  vva_pkg::item_t   e_it_nxt;
  logic [2:0][32:0] e_rnd;
  logic [32:0]      e_drnd;

  always_comb begin
    e_it_nxt = d_it_r;
    for (int k = 0; k < 3; k++) e_rnd[k] = vva_pkg::rnd_sat(d_pair_r[k]);
    e_drnd = vva_pkg::rnd_sat(d_dsum_r);
    unique case (d_it_r.cmd)
      vva_pkg::CMD_SCALE, vva_pkg::CMD_CROSS: begin
        for (int k = 0; k < 3; k++) e_it_nxt.r[k] = e_rnd[k][31:0];
        e_it_nxt.ovf = e_rnd[0][32] | e_rnd[1][32] | e_rnd[2][32];
      end
      vva_pkg::CMD_DOT, vva_pkg::CMD_LENSQ: begin
        e_it_nxt.so  = e_drnd[31:0];
        e_it_nxt.ovf = e_drnd[32];
      end
      default: begin
      end
    endcase
  end

  logic           sq_v_r    [SQ+1];
  logic [63:0]    sq_s_r    [SQ+1];
  logic [34:0]    sq_rem_r  [SQ+1];
  logic [31:0]    sq_root_r [SQ+1];
  vva_pkg::item_t sq_it_r   [SQ+1];
  logic [34:0]    sq_rem2   [SQ];
  logic [34:0]    sq_trial  [SQ];
  logic [63:0]    sq_s_nxt  [SQ];
  logic [34:0]    sq_rem_nxt[SQ];
  logic [31:0]    sq_root_nxt[SQ];

  always_comb begin
    for (int k = 0; k < SQ; k++) begin
      sq_rem2[k]  = {sq_rem_r[k][32:0], sq_s_r[k][63:62]};
      sq_trial[k] = {1'b0, sq_root_r[k], 2'b01};
      sq_s_nxt[k] = {sq_s_r[k][61:0], 2'b00};
      if (sq_rem2[k] >= sq_trial[k]) begin
        sq_rem_nxt[k]  = sq_rem2[k] - sq_trial[k];
        sq_root_nxt[k] = {sq_root_r[k][30:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = sq_rem2[k];
        sq_root_nxt[k] = {sq_root_r[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ; k++) sq_v_r[k] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= d_v_r;
      for (int k = 0; k < SQ; k++) sq_v_r[k+1] <= sq_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_s_r[0]    <= d_dsum_r[63:0];
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_it_r[0]   <= e_it_nxt;
      for (int k = 0; k < SQ; k++) begin
        sq_s_r[k+1]    <= sq_s_nxt[k];
        sq_rem_r[k+1]  <= sq_rem_nxt[k];
        sq_root_r[k+1] <= sq_root_nxt[k];
        sq_it_r[k+1]   <= sq_it_r[k];
      end
    end
  end

  // length, divisor select, divider chain entry
  logic [DW-1:0]    f_len;
  logic [DW-1:0]    f_d;
  logic [32:0]      f_lsat;
  vva_pkg::item_t   f_it_nxt;
  logic [2:0][NW-1:0] f_num;

  always_comb begin
    f_len = {1'b0, sq_root_r[SQ]} +
            ((sq_rem_r[SQ] > {3'b000, sq_root_r[SQ]}) ? 33'd1 : 33'd0);
    f_lsat   = vva_pkg::sat_sm(1'b0, {33'd0, f_len});
    f_it_nxt = sq_it_r[SQ];
    if (sq_it_r[SQ].cmd == vva_pkg::CMD_LEN) begin
      f_it_nxt.so  = f_lsat[31:0];
      f_it_nxt.ovf = f_lsat[32];
    end
    f_it_nxt.dz = ((sq_it_r[SQ].cmd == vva_pkg::CMD_DIV) && sq_it_r[SQ].sczero) ||
                  ((sq_it_r[SQ].cmd == vva_pkg::CMD_NORM) && (f_len == '0));
    f_d = (sq_it_r[SQ].cmd == vva_pkg::CMD_NORM) ? f_len : {1'b0, sq_it_r[SQ].scmag};
    for (int j = 0; j < 3; j++) begin
      f_num[j] = {sq_it_r[SQ].amag[j], {vva_pkg::FRAC_BITS{1'b0}}} + NW'(f_d[DW-1:1]);
    end
  end

  logic               dv_v_r  [DV+1];
  logic [2:0][NW-1:0] dv_nq_r [DV+1];
  logic [2:0][DW-1:0] dv_rem_r[DV+1];
  logic [DW-1:0]      dv_d_r  [DV+1];
  vva_pkg::item_t     dv_it_r [DV+1];
  logic [2:0][DW:0]   dv_r2   [DV];
  logic [2:0][NW-1:0] dv_nq_nxt [DV];
  logic [2:0][DW-1:0] dv_rem_nxt[DV];

  always_comb begin
    for (int k = 0; k < DV; k++) begin
      for (int j = 0; j < 3; j++) begin
        dv_r2[k][j] = {dv_rem_r[k][j], dv_nq_r[k][j][NW-1]};
        if (dv_r2[k][j] >= {1'b0, dv_d_r[k]}) begin
          dv_rem_nxt[k][j] = DW'(dv_r2[k][j] - {1'b0, dv_d_r[k]});
          dv_nq_nxt[k][j]  = {dv_nq_r[k][j][NW-2:0], 1'b1};
        end else begin
          dv_rem_nxt[k][j] = dv_r2[k][j][DW-1:0];
          dv_nq_nxt[k][j]  = {dv_nq_r[k][j][NW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DV; k++) dv_v_r[k] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQ];
      for (int k = 0; k < DV; k++) dv_v_r[k+1] <= dv_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_nq_r[0]  <= f_num;
      dv_rem_r[0] <= '0;
      dv_d_r[0]   <= f_d;
      dv_it_r[0]  <= f_it_nxt;
      for (int k = 0; k < DV; k++) begin
        dv_nq_r[k+1]  <= dv_nq_nxt[k];
        dv_rem_r[k+1] <= dv_rem_nxt[k];
        dv_d_r[k+1]   <= dv_d_r[k];
        dv_it_r[k+1]  <= dv_it_r[k];
      end
    end
  end

  // final assembly
  vva_pkg::item_t   o_it;
  logic [2:0][32:0] o_qs;
  logic [2:0]       o_qneg;
  logic [1:0]       o_status;

  always_comb begin
    o_it = dv_it_r[DV];
    for (int j = 0; j < 3; j++) begin
      o_qneg[j] = (dv_it_r[DV].aneg[j] ^
                   ((dv_it_r[DV].cmd == vva_pkg::CMD_DIV) & dv_it_r[DV].scneg)) &&
                  (dv_nq_r[DV][j] != '0);
      o_qs[j] = vva_pkg::sat_sm(o_qneg[j], 66'(dv_nq_r[DV][j]));
    end
    if ((dv_it_r[DV].cmd == vva_pkg::CMD_DIV) || (dv_it_r[DV].cmd == vva_pkg::CMD_NORM)) begin
      if (dv_it_r[DV].dz) begin
        o_it.r = '0;
      end else begin
        for (int j = 0; j < 3; j++) o_it.r[j] = o_qs[j][31:0];
        o_it.ovf = o_qs[0][32] | o_qs[1][32] | o_qs[2][32];
      end
    end
    priority if (o_it.dz) begin
      o_status = vva_pkg::ST_DZ;
    end else if (o_it.ovf) begin
      o_status = vva_pkg::ST_OVF;
    end else begin
      o_status = vva_pkg::ST_OK;
    end
  end

  logic         out_v_r;
  logic [135:0] out_data_r;
  logic [1:0]   out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v_r[DV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {7'd0, o_it.eq, o_it.so, o_it.r[2], o_it.r[1], o_it.r[0]};
      out_user_r <= o_status;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("undefined status code");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == vva_pkg::ST_DZ) |-> (out_tdata[127:0] == '0))
    else $error("zero divisor result not cleared");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule
